FILE: hdl/nmsd_pkg.sv
// Shared constants and types for the mean squared difference similarity block.
`default_nettype none
package nmsd_pkg;

    localparam int RATING_W   = 4;
    localparam int SUM_W      = 19;
    localparam int CNT_W      = 13;
    localparam int SIM_W      = 14;
    localparam int FULL_W     = 5;
    localparam int PEN_W      = 7;
    localparam int CFG_DATA_W = 7;
    localparam int FRAC_BITS  = 8;
    localparam int MAX_PAIRS  = 4096;

    // Numerator holds sum plus penalty * (N - count); one carry bit above the sum.
    localparam int NUM_W      = SUM_W + 1;
    // (num << FRAC_BITS) / (den * 4) equals (num << (FRAC_BITS - 2)) / den.
    localparam int SCALE_SH   = FRAC_BITS - 2;
    localparam int DVD_W      = NUM_W + SCALE_SH;
    localparam int STEP_W     = $clog2(DVD_W + 1);

    localparam int CNT_FIELD_MAX = (1 << CNT_W) - 1;
    localparam int CNT_LIMIT_I   = (MAX_PAIRS < CNT_FIELD_MAX) ? MAX_PAIRS : CNT_FIELD_MAX;
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(CNT_LIMIT_I);
    localparam logic [SUM_W:0]   SUM_MAX   = {1'b0, {SUM_W{1'b1}}};
    localparam logic [SIM_W-1:0] SIM_MIN_MAG = SIM_W'(1 << (SIM_W - 1));

    localparam logic [FULL_W-1:0] FULL_RESET = FULL_W'(5);
    localparam logic [PEN_W-1:0]  PEN_RESET  = PEN_W'(16);

    // Register indexes on the configuration port
    localparam logic CFG_FULL_SUPPORT = 1'b0;
    localparam logic CFG_PENALTY      = 1'b1;

    typedef struct packed {
        logic               start;
        logic [DVD_W-1:0]   dividend;
        logic [CNT_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DVD_W-1:0]   quotient;
    } div_rsp_t;

endpackage
`default_nettype wire

FILE: hdl/neg_mean_sq_diff_similarity.sv
// Negative mean squared difference similarity of two rating vectors.
//
// Input channel (s_*): one beat per item, rating_a in s_tdata[3:0], rating_b in
// s_tdata[7:4], half-star units, 0 = unrated; s_tlast marks the final pair.
// A pair with both ratings nonzero adds its squared difference (quarter units)
// to a saturating 19-bit sum and bumps the common count (saturates at 4096).
// Output channel (m_*): one beat per vector, after the tlast beat. m_tdata
// carries similarity (signed, 8 fractional bits, stars^2) and common_items;
// m_tuser is the defined flag (0 when no pair was common, similarity then 0).
// Throughput: one pair per cycle while accumulating. After the tlast beat the
// block passes through a setup state, the restoring divider (26 quotient bits
// of the scaled numerator, one per cycle, plus the done flag) and a state that
// loads the output register; s_tready is low throughout (the divider is skipped
// without common pairs); m_tvalid rises when it is loaded. The output
// register lets the next vector stream in while a result waits; a second result
// waits in the block (s_tready low) until m_tready.
// Reset (aresetn, synchronous, low) clears accumulators, drops any pending
// result and restores full_support_count = 5, missing_penalty = 16.
// Configuration: cfg_wr_en with cfg_index 0 = full_support_count[4:0],
// 1 = missing_penalty[6:0]; write only while the block is idle.
`default_nettype none
module neg_mean_sq_diff_similarity (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic                            cfg_index,
    input  wire logic [nmsd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            s_tvalid,
    output      logic                            s_tready,
    input  wire logic [7:0]                      s_tdata,  // rating_a[3:0], rating_b[7:4]
    input  wire logic                            s_tlast,  // last_pair
    output      logic                            m_tvalid,
    input  wire logic                            m_tready,
    output      logic [31:0]                     m_tdata,  // similarity[13:0], common_items[26:14]
    output      logic                            m_tuser   // defined
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]                       state_reg, state_next;
    logic [nmsd_pkg::FULL_W-1:0]      full_reg;
    logic [nmsd_pkg::PEN_W-1:0]       pen_reg;
    logic [nmsd_pkg::SUM_W-1:0]       sum_reg, sum_next;
    logic [nmsd_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic [nmsd_pkg::SIM_W-1:0]       mag_reg, mag_next;
    logic                             m_valid_reg, m_valid_next;
    logic [nmsd_pkg::SIM_W-1:0]       m_sim_reg, m_sim_next;
    logic [nmsd_pkg::CNT_W-1:0]       m_cnt_reg, m_cnt_next;
    logic                             m_def_reg, m_def_next;

    logic                             in_beat;
    logic [nmsd_pkg::RATING_W-1:0]    rating_a, rating_b, diff;
    logic [2*nmsd_pkg::RATING_W-1:0]  diff_sq;
    logic [nmsd_pkg::SUM_W:0]         sum_add;
    logic                             use_mean;
    logic [nmsd_pkg::FULL_W-1:0]      missing;
    logic [nmsd_pkg::PEN_W+nmsd_pkg::FULL_W-1:0] pen_total;
    logic [nmsd_pkg::NUM_W-1:0]       num;
    logic                             out_free;

    nmsd_pkg::div_req_t               div_req;
    nmsd_pkg::div_rsp_t               div_rsp;

    assign rating_a = s_tdata[3:0];
    assign rating_b = s_tdata[7:4];
    assign s_tready = (state_reg == ST_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // Squared difference of one pair, then a saturating add into the sum
    assign diff    = (rating_a > rating_b) ? rating_a - rating_b : rating_b - rating_a;
    assign diff_sq = diff * diff;
    assign sum_add = {1'b0, sum_reg} + (nmsd_pkg::SUM_W + 1)'(diff_sq);

    // Numerator and divisor: plain mean at full support, else pad with penalty
    assign use_mean  = cnt_reg >= nmsd_pkg::CNT_W'(full_reg);
    assign missing   = full_reg - cnt_reg[nmsd_pkg::FULL_W-1:0];
    assign pen_total = pen_reg * missing;
    assign num       = use_mean ? nmsd_pkg::NUM_W'(sum_reg)
                                : nmsd_pkg::NUM_W'(sum_reg) + nmsd_pkg::NUM_W'(pen_total);

    always_comb begin
        state_next       = state_reg;
        sum_next         = sum_reg;
        cnt_next         = cnt_reg;
        mag_next         = mag_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_sim_next       = m_sim_reg;
        m_cnt_next       = m_cnt_reg;
        m_def_next       = m_def_reg;
        div_req.start    = 1'b0;
        div_req.dividend = {num, {nmsd_pkg::SCALE_SH{1'b0}}};
        div_req.divisor  = use_mean ? cnt_reg : nmsd_pkg::CNT_W'(full_reg);
        case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    if (rating_a != '0 && rating_b != '0) begin
                        sum_next = (sum_add > nmsd_pkg::SUM_MAX) ? nmsd_pkg::SUM_MAX[nmsd_pkg::SUM_W-1:0]
                                                                 : sum_add[nmsd_pkg::SUM_W-1:0];
                        if (cnt_reg < nmsd_pkg::CNT_LIMIT) begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                    if (s_tlast) begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                // No common pairs: skip the divider, report undefined
                mag_next = '0;
                if (cnt_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    mag_next = (div_rsp.quotient > nmsd_pkg::DVD_W'(nmsd_pkg::SIM_MIN_MAG))
                             ? nmsd_pkg::SIM_MIN_MAG
                             : div_rsp.quotient[nmsd_pkg::SIM_W-1:0];
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hold until the output register frees, then clear the accumulators
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_sim_next   = nmsd_pkg::SIM_W'(~mag_reg + 1'b1);
                    m_cnt_next   = cnt_reg;
                    m_def_next   = cnt_reg != '0;
                    sum_next     = '0;
                    cnt_next     = '0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            sum_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            full_reg    <= nmsd_pkg::FULL_RESET;
            pen_reg     <= nmsd_pkg::PEN_RESET;
        end else begin
            state_reg   <= state_next;
            sum_reg     <= sum_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                if (cfg_index == nmsd_pkg::CFG_FULL_SUPPORT) begin
                    full_reg <= cfg_wdata[nmsd_pkg::FULL_W-1:0];
                end
                if (cfg_index == nmsd_pkg::CFG_PENALTY) begin
                    pen_reg <= cfg_wdata[nmsd_pkg::PEN_W-1:0];
                end
            end
        end
        mag_reg   <= mag_next;
        m_sim_reg <= m_sim_next;
        m_cnt_reg <= m_cnt_next;
        m_def_reg <= m_def_next;
    end

    nmsd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_cnt_reg, m_sim_reg};
    assign m_tuser  = m_def_reg;

endmodule
`default_nettype wire

FILE: hdl/nmsd_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module nmsd_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire nmsd_pkg::div_req_t req,
    output      nmsd_pkg::div_rsp_t rsp
);

    logic [nmsd_pkg::DVD_W-1:0]  qd_reg, qd_next;
    logic [nmsd_pkg::CNT_W-1:0]  rem_reg, rem_next;
    logic [nmsd_pkg::CNT_W-1:0]  den_reg, den_next;
    logic [nmsd_pkg::STEP_W-1:0] step_reg, step_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [nmsd_pkg::CNT_W:0]    trial;
    logic                        fits;

    // Shift the next dividend bit into the partial remainder and trial-subtract.
    assign trial = {rem_reg, qd_reg[nmsd_pkg::DVD_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb begin
        qd_next   = qd_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            qd_next   = req.dividend;
            rem_next  = '0;
            den_next  = req.divisor;
            step_next = nmsd_pkg::STEP_W'(nmsd_pkg::DVD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = fits ? nmsd_pkg::CNT_W'(trial - {1'b0, den_reg})
                             : trial[nmsd_pkg::CNT_W-1:0];
            qd_next   = {qd_reg[nmsd_pkg::DVD_W-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == nmsd_pkg::STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        qd_reg  <= qd_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = qd_reg;

endmodule
`default_nettype wire

FILE: tb/tb_neg_mean_sq_diff_similarity.sv
// Self-checking testbench for the negative mean squared difference similarity block.

// One expected result beat: similarity and common count travel in m_tdata, defined in m_tuser.
typedef struct packed {
    logic [nmsd_pkg::SIM_W-1:0] similarity;
    logic                       defined;
    logic [nmsd_pkg::CNT_W-1:0] common_items;
} sim_result_t;

// Tracks both accumulators and the two registers, and queues one result per closed vector.
class sim_scoreboard;
    logic [nmsd_pkg::FULL_W-1:0] full_n  = nmsd_pkg::FULL_RESET;
    logic [nmsd_pkg::PEN_W-1:0]  penalty = nmsd_pkg::PEN_RESET;
    longint unsigned             sum_acc = 0;
    int unsigned                 pair_count = 0;
    sim_result_t                 want_q[$];
    int                          errors = 0;

    function void write_reg(logic idx, logic [nmsd_pkg::CFG_DATA_W-1:0] val);
        if (idx == nmsd_pkg::CFG_FULL_SUPPORT) begin
            full_n = val[nmsd_pkg::FULL_W-1:0];
        end else begin
            penalty = val[nmsd_pkg::PEN_W-1:0];
        end
    endfunction

    function int pending();
        return want_q.size();
    endfunction

    // Accumulate one accepted pair; on the last pair close the vector.
    function void note_pair(logic [3:0] a, logic [3:0] b, logic last);
        int unsigned     diff;
        longint unsigned num;
        longint unsigned den;
        longint unsigned mag;
        sim_result_t     want;
        if (a != 4'd0 && b != 4'd0) begin
            diff = (a > b) ? a - b : b - a;
            sum_acc = sum_acc + diff * diff;
            if (sum_acc > (64'd1 << nmsd_pkg::SUM_W) - 1)
                sum_acc = (64'd1 << nmsd_pkg::SUM_W) - 1;
            if (pair_count < nmsd_pkg::CNT_LIMIT_I)
                pair_count++;
        end
        if (!last)
            return;
        if (pair_count == 0) begin
            want = '0;
        end else begin
            if (pair_count >= full_n) begin
                num = sum_acc;
                den = pair_count;
            end else begin
                // Too few common items: charge the penalty for each missing one.
                num = sum_acc + longint'(penalty) * (full_n - pair_count);
                den = full_n;
            end
            mag = (num << nmsd_pkg::FRAC_BITS) / (den * 4);
            if (mag > (64'd1 << (nmsd_pkg::SIM_W - 1)))
                mag = 64'd1 << (nmsd_pkg::SIM_W - 1);
            want.similarity   = nmsd_pkg::SIM_W'(64'd0 - mag);
            want.defined      = 1'b1;
            want.common_items = nmsd_pkg::CNT_W'(pair_count);
        end
        want_q.push_back(want);
        sum_acc    = 0;
        pair_count = 0;
    endfunction

    // Compare one accepted result beat with the oldest expectation.
    function void check_result(logic [31:0] tdata, logic tuser);
        sim_result_t want;
        if (want_q.size() == 0) begin
            $error("result beat with no vector pending: tdata %h tuser %b", tdata, tuser);
            errors++;
            return;
        end
        want = want_q.pop_front();
        if (tdata[13:0] != want.similarity) begin
            $error("similarity mismatch: expected %0d, got %0d",
                   $signed(want.similarity), $signed(tdata[13:0]));
            errors++;
        end
        if (tuser != want.defined) begin
            $error("defined mismatch: expected %0d, got %0d", want.defined, tuser);
            errors++;
        end
        if (tdata[26:14] != want.common_items) begin
            $error("common_items mismatch: expected %0d, got %0d",
                   want.common_items, tdata[26:14]);
            errors++;
        end
        if (tdata[31:27] != 5'd0) begin
            $error("tdata padding mismatch: expected 0, got %0d", tdata[31:27]);
            errors++;
        end
    endfunction
endclass

module tb_neg_mean_sq_diff_similarity;

    localparam int CYCLE_LIMIT     = 600000;
    localparam int SETTLE_CYCLES   = 40;    // divider pass plus output load, with margin
    localparam int HOLD_CYCLES     = 300;   // long receiver hold-off
    localparam int PAIRS_PER_PHASE = 110;
    localparam int NUM_PHASES      = 8;
    localparam int LONG_PAIRS      = 200;   // long vector of largest differences

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = nmsd_pkg::CFG_FULL_SUPPORT;
    logic [nmsd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;   // rating_a[3:0], rating_b[7:4]
    logic        s_tlast   = 1'b0; // last_pair
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // similarity[13:0], common_items[26:14]
    logic        m_tuser;          // defined

    // Idle rates in percent per cycle, set per phase by the stimulus process.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int cycle_count   = 0;

    // Register plan per phase; phase 0 runs on reset values, the last one is random.
    logic [6:0] full_plan [NUM_PHASES] = '{7'd5, 7'd1, 7'd16, 7'd0, 7'd31, 7'h72, 7'd2, 7'd5};
    logic [6:0] pen_plan  [NUM_PHASES] = '{7'd16, 7'd0, 7'd100, 7'd127, 7'd127, 7'd50, 7'd85,
                                           7'd16};

    sim_scoreboard sb = new();

    neg_mean_sq_diff_similarity i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Bound the run; a hang ends here.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Sample result beats at the rising edge, before the block updates its outputs.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    // Receiver: drive tready at the falling edge; honor a hold-off request by
    // holding tready low for a long stretch counted here.
    initial begin
        int seen_holds;
        int hold_left;
        seen_holds = 0;
        hold_left  = 0;
        forever begin
            @(negedge aclk);
            if (hold_left == 0 && seen_holds != hold_requests) begin
                seen_holds = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
            end
        end
    end

    // Offer one pair, idling at random first; return at the falling edge after the beat.
    task automatic send_pair(input logic [3:0] a, input logic [3:0] b, input logic last);
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
            // Drive junk while idle; it must be ignored.
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tlast  <= 1'($urandom);
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_pair(a, b, last);
        @(negedge aclk);
    endtask

    // Drop valid, wait for every result, then let the divider settle.
    task automatic finish_phase();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Write one register; the block must be idle.
    task automatic write_reg(input logic idx, input logic [6:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(idx, val);
        @(negedge aclk);
    endtask

    // Mostly valid ratings, some unrated, a few out of the nominal range.
    function automatic logic [3:0] rand_rating();
        int r;
        r = $urandom_range(99, 0);
        if (r < 15)
            return 4'd0;
        if (r < 90)
            return 4'($urandom_range(10, 1));
        return 4'($urandom_range(15, 11));
    endfunction

    // Mostly short vectors so results come often; a few long ones.
    function automatic int pick_length();
        int r;
        r = $urandom_range(99, 0);
        if (r < 70)
            return $urandom_range(8, 1);
        if (r < 95)
            return $urandom_range(24, 9);
        return $urandom_range(80, 25);
    endfunction

    task automatic send_random_vector(input int len);
        int         shape;
        logic [3:0] a;
        logic [3:0] b;
        shape = $urandom_range(9, 0);
        for (int i = 0; i < len; i++) begin
            a = rand_rating();
            b = rand_rating();
            if (shape == 0) begin
                // Second user rated nothing: no common items.
                b = 4'd0;
            end else if (shape == 1) begin
                // Extreme ratings only: drives the largest differences.
                a = $urandom_range(1, 0) ? 4'd15 : 4'd1;
                b = $urandom_range(1, 0) ? 4'd15 : 4'd1;
            end
            send_pair(a, b, i == len - 1);
        end
    endtask

    initial begin
        int         sent;
        int         len;
        logic [6:0] full_val;
        logic [6:0] pen_val;

        // Hold reset, then release it at a falling edge.
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < 3) begin
                send_idle_pct = 33;
                recv_idle_pct = 50;
            end else if (p < 6) begin
                send_idle_pct = 50;
                recv_idle_pct = 33;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            if (p == 0) begin
                // Directed part on reset settings (N = 5, penalty 16).
                send_pair(4'd10, 4'd1, 1'b1);   // one common item, penalty applies
                send_pair(4'd0, 4'd7, 1'b1);    // no common items
                send_pair(4'd0, 4'd0, 1'b1);    // both unrated
                send_pair(4'd15, 4'd1, 1'b0);   // ratings above the nominal range
                send_pair(4'd1, 4'd15, 1'b0);
                send_pair(4'd15, 4'd15, 1'b0);
                send_pair(4'd10, 4'd10, 1'b0);
                send_pair(4'd5, 4'd0, 1'b1);    // last pair not counted
                for (int v = 1; v <= 5; v++)
                    send_pair(4'(v), 4'(v), v == 5);  // identical ratings, plain mean of zero
                send_pair(4'd3, 4'd9, 1'b0);
                send_pair(4'd9, 4'd3, 1'b0);
                send_pair(4'd2, 4'd0, 1'b0);
                send_pair(4'd7, 4'd8, 1'b0);
                send_pair(4'd1, 4'd10, 1'b0);
                send_pair(4'd10, 4'd1, 1'b1);   // exactly N common items
                // One long vector of largest differences: the plain mean saturates low.
                for (int i = 0; i < LONG_PAIRS; i++)
                    send_pair(4'd15, 4'd1, i == LONG_PAIRS - 1);
            end else begin
                full_val = full_plan[p];
                pen_val  = pen_plan[p];
                if (p == NUM_PHASES - 1) begin
                    full_val = 7'($urandom_range(16, 1));
                    pen_val  = 7'($urandom_range(100, 0));
                end
                write_reg(nmsd_pkg::CFG_FULL_SUPPORT, full_val);
                write_reg(nmsd_pkg::CFG_PENALTY, pen_val);
            end

            // Single-pair vectors per setting: low saturation when N <= 1, penalty otherwise.
            send_pair(4'd15, 4'd1, 1'b1);
            send_pair(4'd1, 4'd2, 1'b1);

            // Stall the receiver for a long stretch while the sender keeps going.
            if (p == 4)
                hold_requests++;

            sent = 0;
            while (sent < PAIRS_PER_PHASE) begin
                len = pick_length();
                send_random_vector(len);
                sent += len;
            end
            finish_phase();
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
